/* rtl/rls_pkg.sv */
package rls_pkg;

   // Step codes for the shared multiply pipeline
   typedef enum logic [2:0] {
      OP_Y,    // filter output: taps times weights
      OP_G,    // gain: P times taps
      OP_Q,    // taps times gain
      OP_W,    // weight update
      OP_P     // inverse correlation update
   } op_type;

   typedef struct packed {
      logic   clear;      // clearing sweep write
      logic   load;       // transaction accepted: write new sample
      logic   issue;      // issue one step into the multiply pipeline
      op_type op;
      logic   first;      // first step of a sum
      logic   last;       // last step of a sum
      logic   div_start;
      logic   k_write;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      logic busy;         // multiply pipeline holds steps
      logic div_done;
      logic out_free;     // output register can take a result
   } sts_type;

   localparam int WIDE_W = 66;

   localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
   localparam logic signed [31:0] MAX32   = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN32   = 32'sh80000000;
   localparam int QUOT_W = 32;

   // Shift right, rounding half toward plus infinity
   function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned s);
      logic signed [WIDE_W-1:0] bias;
      bias = {{(WIDE_W-1){1'b0}}, 1'b1} << (s - 1);
      return (v + bias) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > 66'sd2147483647) begin
         return MAX32;
      end else if (v < -66'sd2147483648) begin
         return MIN32;
      end else begin
         return signed'(v[31:0]);
      end
   endfunction

   function automatic logic signed [17:0] sat18(input logic signed [WIDE_W-1:0] v);
      if (v > 66'sd131071) begin
         return 18'sh1FFFF;
      end else if (v < -66'sd131072) begin
         return 18'sh20000;
      end else begin
         return signed'(v[17:0]);
      end
   endfunction

endpackage

/* rtl/rls_ram.sv */
module rls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rls_div.sv */
// Rounded quotient g*2^24/den, one quotient bit per cycle
module rls_div #(
   parameter int DEN_W = 41
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      g,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [31:0]      quot
);

   localparam int QW    = rls_pkg::QUOT_W;
   localparam int NUM_W = ((DEN_W > 56) ? DEN_W : 56) + 1;
   localparam int CW    = $clog2(QW + 1);

   logic signed [32:0]  g_ext;
   logic [32:0]         mag_g;
   logic [NUM_W-1:0]    numer;
   logic                ovf;
   logic [DEN_W:0]      trial;
   logic                ge;
   logic [DEN_W-1:0]    rem_in;
   logic [QW-1:0]       q_in;
   logic signed [31:0]  res;

   logic [DEN_W-1:0]    rem_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [QW-1:0]       lo_ff;
   logic [QW-1:0]       q_ff;
   logic                neg_ff;
   logic [CW-1:0]       cnt_ff;
   logic                run_ff;
   logic                done_ff;
   logic signed [31:0]  quot_ff;

   always_comb begin
      g_ext = 33'(g);
      mag_g = g_ext[32] ? unsigned'(-g_ext) : unsigned'(g_ext);
      numer = NUM_W'({mag_g, 24'd0}) + NUM_W'(den >> 1);
      ovf   = DEN_W'(numer[NUM_W-1:QW]) >= den;
      trial = {rem_ff, lo_ff[QW-1]};
      ge    = trial >= {1'b0, den_ff};
      rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
      q_in  = {q_ff[QW-2:0], ge};
      if (!neg_ff) begin
         res = q_in[QW-1] ? rls_pkg::MAX32 : signed'(q_in);
      end else begin
         res = (q_in > 32'h80000000) ? rls_pkg::MIN32 : signed'(-q_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff <= den;
            neg_ff <= g[31];
            if (ovf) begin
               done_ff <= 1'b1;
               quot_ff <= g[31] ? rls_pkg::MIN32 : rls_pkg::MAX32;
            end else begin
               rem_ff <= DEN_W'(numer[NUM_W-1:QW]);
               lo_ff  <= numer[QW-1:0];
               q_ff   <= '0;
               cnt_ff <= CW'(QW);
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            rem_ff <= rem_in;
            lo_ff  <= lo_ff << 1;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= res;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("divide started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divide done held");

endmodule

/* rtl/rls_ctrl.sv */
module rls_ctrl #(
   parameter int TAPS = 8,
   localparam int IW = $clog2(TAPS),
   localparam int LW = $clog2(TAPS * TAPS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rls_pkg::sts_type sts,
   output rls_pkg::cmd_type cmd,
   output logic [IW-1:0]    idx_i,
   output logic [IW-1:0]    idx_j,
   output logic [LW-1:0]    lin,
   output logic [IW-1:0]    tap_addr
);

   localparam logic [IW-1:0] LAST_IDX = IW'(TAPS - 1);
   localparam logic [LW-1:0] LAST_LIN = LW'(TAPS * TAPS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_Y, S_Y_DRAIN, S_G, S_G_DRAIN, S_Q, S_Q_DRAIN,
      S_K_READ, S_K_START, S_K_WAIT, S_W, S_W_DRAIN, S_P, S_P_DRAIN, S_DONE
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] i_ff, j_ff, tp_ff, head_ff;
   logic [LW-1:0] lin_ff;
   logic          i_last, j_last, lin_last;
   logic [IW-1:0] tp_inc, head_dec;

   always_comb begin
      i_last   = (i_ff == LAST_IDX);
      j_last   = (j_ff == LAST_IDX);
      lin_last = (lin_ff == LAST_LIN);
      tp_inc   = (tp_ff == LAST_IDX) ? '0 : tp_ff + 1'b1;
      head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: cmd.clear = 1'b1;
         S_IDLE:  cmd.load = req_valid;
         S_Y: begin
            cmd.issue = 1'b1;
            cmd.op    = rls_pkg::OP_Y;
            cmd.first = (i_ff == '0);
            cmd.last  = i_last;
         end
         S_G: begin
            cmd.issue = 1'b1;
            cmd.op    = rls_pkg::OP_G;
            cmd.first = (j_ff == '0);
            cmd.last  = j_last;
         end
         S_Q: begin
            cmd.issue = 1'b1;
            cmd.op    = rls_pkg::OP_Q;
            cmd.first = (i_ff == '0);
            cmd.last  = i_last;
         end
         S_K_START: cmd.div_start = 1'b1;
         S_K_WAIT:  cmd.k_write = sts.div_done;
         S_W: begin
            cmd.issue = 1'b1;
            cmd.op    = rls_pkg::OP_W;
         end
         S_P: begin
            cmd.issue = 1'b1;
            cmd.op    = rls_pkg::OP_P;
         end
         S_DONE:  cmd.rsp_load = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         i_ff     <= '0;
         j_ff     <= '0;
         lin_ff   <= '0;
         tp_ff    <= '0;
         head_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               lin_ff <= lin_ff + 1'b1;
               if (j_last) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
               if (lin_last) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  lin_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  head_ff  <= head_dec;
                  tp_ff    <= head_dec;
                  i_ff     <= '0;
                  state_ff <= S_Y;
               end
            end
            S_Y, S_Q: begin
               i_ff  <= i_ff + 1'b1;
               tp_ff <= tp_inc;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= (state_ff == S_Y) ? S_Y_DRAIN : S_Q_DRAIN;
               end
            end
            S_Y_DRAIN, S_W_DRAIN: begin
               if (!sts.busy) begin
                  tp_ff    <= head_ff;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  lin_ff   <= '0;
                  state_ff <= (state_ff == S_Y_DRAIN) ? S_G : S_P;
               end
            end
            S_G, S_P: begin
               lin_ff <= lin_ff + 1'b1;
               if (j_last) begin
                  j_ff  <= '0;
                  tp_ff <= head_ff;
                  i_ff  <= i_ff + 1'b1;
                  if (i_last) begin
                     i_ff     <= '0;
                     lin_ff   <= '0;
                     state_ff <= (state_ff == S_G) ? S_G_DRAIN : S_P_DRAIN;
                  end
               end else begin
                  j_ff  <= j_ff + 1'b1;
                  tp_ff <= tp_inc;
               end
            end
            S_G_DRAIN: begin
               if (!sts.busy) begin
                  tp_ff    <= head_ff;
                  i_ff     <= '0;
                  state_ff <= S_Q;
               end
            end
            S_Q_DRAIN: begin
               if (!sts.busy) begin
                  i_ff     <= '0;
                  state_ff <= S_K_READ;
               end
            end
            S_K_READ:  state_ff <= S_K_START;
            S_K_START: state_ff <= S_K_WAIT;
            S_K_WAIT: begin
               if (sts.div_done) begin
                  if (i_last) begin
                     i_ff     <= '0;
                     state_ff <= S_W;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_K_READ;
                  end
               end
            end
            S_W: begin
               i_ff <= i_ff + 1'b1;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_W_DRAIN;
               end
            end
            S_P_DRAIN: begin
               if (!sts.busy) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign idx_i     = i_ff;
   assign idx_j     = j_ff;
   assign lin       = lin_ff;
   assign tap_addr  = (state_ff == S_IDLE) ? head_dec : tp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("second transaction taken");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> !req_stall) else $error("not idle after result load");

endmodule

/* rtl/rls_dp.sv */
module rls_dp #(
   parameter int TAPS = 8,
   localparam int IW = $clog2(TAPS),
   localparam int LW = $clog2(TAPS * TAPS)
) (
   input  logic               clock,
   input  logic               reset,
   input  rls_pkg::cmd_type   cmd,
   output rls_pkg::sts_type   sts,
   input  logic [IW-1:0]      idx_i,
   input  logic [IW-1:0]      idx_j,
   input  logic [LW-1:0]      lin,
   input  logic [IW-1:0]      tap_addr,
   input  logic signed [15:0] req_input_sample,
   input  logic signed [15:0] req_desired_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_error_sample,
   output logic signed [17:0] rsp_filter_output
);

   localparam int WW    = rls_pkg::WIDE_W;
   localparam int ACC_W = 48 + $clog2(TAPS);
   localparam int E_W   = ACC_W + 1;
   localparam int DEN_W = ACC_W - 14;

   typedef struct packed {
      logic            valid;
      rls_pkg::op_type op;
      logic            first;
      logic            last;
      logic [IW-1:0]   i;
      logic [LW-1:0]   lin;
   } tag_type;

   tag_type s1_ff, s2_ff, s3_ff, s1_in;

   logic [15:0] tap_rd;
   logic [31:0] w_rd, g_rd, k_rd, p_rd;

   logic signed [31:0]      mul_a, mul_b, tap_ext;
   logic signed [63:0]      prod_ff;
   logic signed [31:0]      aux_ff;
   logic signed [ACC_W-1:0] acc_ff, prod_acc;
   logic signed [E_W-1:0]   e39_ff;
   logic signed [ACC_W-1:0] y39_ff;
   logic signed [31:0]      e24_ff;
   logic signed [17:0]      eo_ff, yo_ff;
   logic signed [15:0]      desired_ff;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [WW-1:0]    acc_wide, q24, den_s;
   logic signed [31:0]      w_new, p_new, g_new;
   logic                    s2_acc, clr_row;

   logic              tap_we, w_we, p_we, g_we;
   logic [IW-1:0]     tap_wa, w_wa;
   logic [LW-1:0]     p_wa;
   logic [15:0]       tap_wd;
   logic [31:0]       w_wd, p_wd;
   logic [IW-1:0]     k_ra;

   logic               div_done;
   logic signed [31:0] div_quot;

   logic               rsp_valid_ff;
   logic signed [17:0] rsp_err_ff, rsp_out_ff;

   // RAM write and read ports
   always_comb begin
      clr_row = cmd.clear && (lin < LW'(TAPS));
      tap_we  = clr_row || cmd.load;
      tap_wa  = cmd.clear ? lin[IW-1:0] : tap_addr;
      tap_wd  = cmd.clear ? '0 : req_input_sample;
      w_we    = clr_row || (s2_ff.valid && s2_ff.op == rls_pkg::OP_W);
      w_wa    = cmd.clear ? lin[IW-1:0] : s2_ff.i;
      w_wd    = cmd.clear ? '0 : w_new;
      p_we    = cmd.clear || (s2_ff.valid && s2_ff.op == rls_pkg::OP_P);
      p_wa    = cmd.clear ? lin : s2_ff.lin;
      p_wd    = cmd.clear ? ((idx_i == idx_j) ? rls_pkg::ONE_Q24 : '0) : p_new;
      g_we    = s3_ff.valid && s3_ff.last && s3_ff.op == rls_pkg::OP_G;
      k_ra    = (cmd.op == rls_pkg::OP_P) ? idx_j : idx_i;
   end

   rls_ram #(.WIDTH(16), .DEPTH(TAPS)) u_tap_ram (
      .clock(clock), .wr_en(tap_we), .wr_addr(tap_wa), .wr_data(tap_wd),
      .rd_addr(tap_addr), .rd_data(tap_rd));
   rls_ram #(.WIDTH(32), .DEPTH(TAPS)) u_w_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(idx_i), .rd_data(w_rd));
   rls_ram #(.WIDTH(32), .DEPTH(TAPS)) u_g_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(s3_ff.i), .wr_data(g_new),
      .rd_addr(idx_i), .rd_data(g_rd));
   rls_ram #(.WIDTH(32), .DEPTH(TAPS)) u_k_ram (
      .clock(clock), .wr_en(cmd.k_write), .wr_addr(idx_i), .wr_data(div_quot),
      .rd_addr(k_ra), .rd_data(k_rd));
   rls_ram #(.WIDTH(32), .DEPTH(TAPS * TAPS)) u_p_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(lin), .rd_data(p_rd));

   rls_div #(.DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .g(signed'(g_rd)),
      .den(den_ff), .done(div_done), .quot(div_quot));

   // Multiplier operand select
   always_comb begin
      s1_in.valid = cmd.issue;
      s1_in.op    = cmd.op;
      s1_in.first = cmd.first;
      s1_in.last  = cmd.last;
      s1_in.i     = idx_i;
      s1_in.lin   = lin;
      tap_ext = 32'(signed'(tap_rd));
      unique case (s1_ff.op)
         rls_pkg::OP_Y: begin mul_a = tap_ext; mul_b = signed'(w_rd); end
         rls_pkg::OP_G: begin mul_a = tap_ext; mul_b = signed'(p_rd); end
         rls_pkg::OP_Q: begin mul_a = tap_ext; mul_b = signed'(g_rd); end
         rls_pkg::OP_W: begin mul_a = e24_ff; mul_b = signed'(k_rd); end
         rls_pkg::OP_P: begin mul_a = signed'(g_rd); mul_b = signed'(k_rd); end
         default:       begin mul_a = tap_ext; mul_b = signed'(w_rd); end
      endcase
   end

   // Accumulate, write-back and end-of-sum arithmetic
   always_comb begin
      prod_acc = signed'(prod_ff[ACC_W-1:0]);
      s2_acc   = s2_ff.valid && (s2_ff.op == rls_pkg::OP_Y || s2_ff.op == rls_pkg::OP_G ||
                                 s2_ff.op == rls_pkg::OP_Q);
      w_new    = rls_pkg::sat32(WW'(aux_ff) + rls_pkg::rnd_shr(WW'(prod_ff), 24));
      p_new    = rls_pkg::sat32(WW'(aux_ff) - rls_pkg::rnd_shr(WW'(prod_ff), 24));
      acc_wide = WW'(acc_ff);
      g_new    = rls_pkg::sat32(rls_pkg::rnd_shr(acc_wide, 15));
      q24      = rls_pkg::rnd_shr(acc_wide, 15);
      den_s    = WW'(rls_pkg::ONE_Q24) + q24;
      den_in   = (den_s < WW'(1)) ? DEN_W'(1) : DEN_W'(den_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_err_ff   <= eo_ff;
            rsp_out_ff   <= yo_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         desired_ff <= req_desired_sample;
      end
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      aux_ff  <= (s1_ff.op == rls_pkg::OP_W) ? signed'(w_rd) : signed'(p_rd);
      if (s2_acc) begin
         acc_ff <= s2_ff.first ? prod_acc : acc_ff + prod_acc;
      end
      if (s3_ff.valid && s3_ff.last && s3_ff.op == rls_pkg::OP_Y) begin
         y39_ff <= acc_ff;
         e39_ff <= (E_W'(desired_ff) <<< 24) - E_W'(acc_ff);
      end
      if (s3_ff.valid && s3_ff.last && s3_ff.op == rls_pkg::OP_Q) begin
         den_ff <= den_in;
      end
      e24_ff <= rls_pkg::sat32(rls_pkg::rnd_shr(WW'(e39_ff), 15));
      eo_ff  <= rls_pkg::sat18(rls_pkg::rnd_shr(WW'(e39_ff), 24));
      yo_ff  <= rls_pkg::sat18(rls_pkg::rnd_shr(WW'(y39_ff), 24));
   end

   always_comb begin
      sts.busy     = s1_ff.valid || s2_ff.valid || s3_ff.valid;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_sample  = rsp_err_ff;
   assign rsp_filter_output = rsp_out_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overwritten");
   a_kwrite_done: assert property (@(posedge clock) disable iff (reset)
      cmd.k_write |-> div_done) else $error("gain written without quotient");

endmodule

/* rtl/rls_adaptive_fir.sv */
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    input_sample s16, desired_sample s16
// rsp       out        rsp_valid/stall    error_sample s18, filter_output s18
//
// One transaction at a time. A sample makes five passes through the one shared
// multiplier pipeline, two of them over P, with a drain after each pass, plus
// for each gain the read and the bit-serial divide.
// After reset a clearing pass loads P with the identity and zeroes taps and
// weights; req_stall stays high through it.
// The result waits in an output register; the next transaction is taken while it
// is held by rsp_stall.
module rls_adaptive_fir #(
   parameter int TAPS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_input_sample,
   input  logic signed [15:0] req_desired_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_error_sample,
   output logic signed [17:0] rsp_filter_output
);

   localparam int IW = $clog2(TAPS);
   localparam int LW = $clog2(TAPS * TAPS);

   rls_pkg::cmd_type cmd;
   rls_pkg::sts_type sts;
   logic [IW-1:0]    idx_i, idx_j, tap_addr;
   logic [LW-1:0]    lin;

   // Sequencer: clearing sweep, then per transaction the output sum, gain,
   // denominator, divides, weight update and P update
   rls_ctrl #(.TAPS(TAPS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .sts(sts), .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j), .lin(lin),
      .tap_addr(tap_addr));

   // Storage, multiply pipeline, divider and output register
   rls_dp #(.TAPS(TAPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .idx_i(idx_i),
      .idx_j(idx_j), .lin(lin), .tap_addr(tap_addr),
      .req_input_sample(req_input_sample), .req_desired_sample(req_desired_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_error_sample(rsp_error_sample), .rsp_filter_output(rsp_filter_output));

endmodule
